@@ rtl/hcse_pkg.sv @@
// hcse_pkg: shared widths, register indexes, run mode codes and commutation tables
// for the hall commutation speed estimator; no dependencies
package hcse_pkg;

  localparam int HALL_W = 3;
  localparam int MODE_W = 2;
  localparam int PAT_W  = 3;
  localparam int K_W    = 11;
  localparam int CNT_W  = 16;
  localparam int SPD_W  = 17;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 17;

  // bit-serial multiplier: k (K_W bits) times x (SPD_W bits)
  localparam int PROD_W   = K_W + SPD_W;
  localparam int Q_SHIFT  = 10;
  localparam int FRAC_W   = PROD_W - Q_SHIFT;
  localparam int MUL_CW   = $clog2(K_W + 1);
  localparam logic [MUL_CW-1:0] MUL_STEPS = MUL_CW'(K_W);

  // bit-serial divider: SPD_W-bit dividend over CNT_W-bit divisor
  localparam int DIV_CW   = $clog2(SPD_W + 1);
  localparam logic [DIV_CW-1:0] DIV_STEPS = DIV_CW'(SPD_W);

  localparam logic [CNT_W-1:0] PERIOD_MAX = {CNT_W{1'b1}};
  localparam logic [SPD_W-1:0] SPEED_MAX  = SPD_W'(65536);

  // configuration register indexes
  localparam logic [CFG_IW-1:0] REG_FILTER_K1   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_FILTER_K2   = 2'd1;
  localparam logic [CFG_IW-1:0] REG_SPEED_NUM   = 2'd2;
  localparam logic [CFG_IW-1:0] REG_STALL_LIMIT = 2'd3;

  localparam logic [K_W-1:0]   RST_FILTER_K1   = 11'd355;
  localparam logic [K_W-1:0]   RST_FILTER_K2   = 11'd669;
  localparam logic [SPD_W-1:0] RST_SPEED_NUM   = 17'd16384;
  localparam logic [CNT_W-1:0] RST_STALL_LIMIT = 16'd2000;

  // run modes
  localparam logic [MODE_W-1:0] MODE_REV = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FWD = 2'd2;

  localparam logic [PAT_W-1:0] PAT_NONE = 3'd0;

  typedef struct packed {
    logic             start;
    logic [K_W-1:0]   k;
    logic [SPD_W-1:0] x;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [SPD_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  function automatic logic [PAT_W-1:0] fwd_pattern(input logic [HALL_W-1:0] h);
    logic [PAT_W-1:0] p;
    unique case (h)
      3'd1:    p = 3'd6;
      3'd2:    p = 3'd2;
      3'd3:    p = 3'd1;
      3'd4:    p = 3'd4;
      3'd5:    p = 3'd5;
      3'd6:    p = 3'd3;
      default: p = PAT_NONE;
    endcase
    return p;
  endfunction

  function automatic logic [PAT_W-1:0] rev_pattern(input logic [HALL_W-1:0] h);
    logic [PAT_W-1:0] p;
    unique case (h)
      3'd1:    p = 3'd3;
      3'd2:    p = 3'd5;
      3'd3:    p = 3'd4;
      3'd4:    p = 3'd1;
      3'd5:    p = 3'd2;
      3'd6:    p = 3'd6;
      default: p = PAT_NONE;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/hcse_mul.sv @@
// hcse_mul: bit-serial shift-add multiplier, one bit of k per cycle
// depends on hcse_pkg
module hcse_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  hcse_pkg::mul_req_t                 req,
  output logic [hcse_pkg::PROD_W-1:0]        product,
  output logic                               done
);

  logic [hcse_pkg::K_W-1:0]    k_sh;
  logic [hcse_pkg::PROD_W-1:0] x_sh;
  logic [hcse_pkg::MUL_CW-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == hcse_pkg::MUL_CW'(1));
      if (req.start) begin
        cnt     <= hcse_pkg::MUL_STEPS;
        product <= '0;
        k_sh    <= req.k;
        x_sh    <= hcse_pkg::PROD_W'(req.x);
      end else if (cnt != '0) begin
        if (k_sh[0]) begin
          product <= product + x_sh;
        end
        k_sh <= k_sh >> 1;
        x_sh <= x_sh << 1;
        cnt  <= cnt - hcse_pkg::MUL_CW'(1);
      end
    end
  end

endmodule

@@ rtl/hcse_div.sv @@
// hcse_div: restoring bit-serial divider, one quotient bit per cycle
// depends on hcse_pkg
module hcse_div (
  input  logic                              clk,
  input  logic                              rst,
  input  hcse_pkg::div_req_t                req,
  output logic [hcse_pkg::SPD_W-1:0]        quotient,
  output logic                              done
);

  logic [hcse_pkg::CNT_W-1:0]  rem;
  logic [hcse_pkg::CNT_W-1:0]  dsr;
  logic [hcse_pkg::DIV_CW-1:0] cnt;
  logic [hcse_pkg::CNT_W:0]    trial;
  logic [hcse_pkg::CNT_W:0]    diff;
  logic                        qbit;

  always_comb begin
    trial = {rem, quotient[hcse_pkg::SPD_W-1]};
    diff  = trial - {1'b0, dsr};
    qbit  = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == hcse_pkg::DIV_CW'(1));
      if (req.start) begin
        cnt      <= hcse_pkg::DIV_STEPS;
        rem      <= '0;
        dsr      <= req.divisor;
        quotient <= req.dividend;
      end else if (cnt != '0) begin
        rem      <= qbit ? diff[hcse_pkg::CNT_W-1:0] : trial[hcse_pkg::CNT_W-1:0];
        quotient <= {quotient[hcse_pkg::SPD_W-2:0], qbit};
        cnt      <= cnt - hcse_pkg::DIV_CW'(1);
      end
    end
  end

endmodule

@@ rtl/hall_commutation_speed_estimator.sv @@
// hall_commutation_speed_estimator: top level, hall commutation and speed filter
// depends on hcse_pkg, hcse_mul, hcse_div
//
// one input word per pwm period on the hall channel (hall_valid / hall_stall),
// one result word per input word on the result channel (result_valid / result_stall)
// configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be written
// by the user while idle (the block does not enforce this); a word with drive off,
// or with the hall code unchanged, gives its result in the cycle after it is taken
// a hall code change runs two period filter products, one division and two
// speed filter products through a shared 11-step bit-serial multiplier and a
// 17-step bit-serial divider, and skips the division when the filtered period is zero
// the block takes one word at a time: hall_stall is high while a change is
// being computed and while the result register holds a word that is stalled
// a finished result waits in the result register until result_stall is low;
// the next input word may be taken in the cycle the result leaves
// reset clears all filter state, the period counter and the hall history,
// and loads the filter weights 355 and 669, numerator 16384 and stall limit 2000
module hall_commutation_speed_estimator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               hall_valid,
  output logic                               hall_stall,
  input  logic [hcse_pkg::HALL_W-1:0]        hall_code,
  input  logic                               drive_enable,
  input  logic [hcse_pkg::MODE_W-1:0]        dir_mode,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [hcse_pkg::PAT_W-1:0]         drive_pattern,
  output logic [hcse_pkg::SPD_W-1:0]         speed_raw,
  output logic [hcse_pkg::SPD_W-1:0]         speed_filtered,
  output logic                               stall_event,
  input  logic                               cfg_we,
  input  logic [hcse_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [hcse_pkg::CFG_DW-1:0]        cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL_A = 3'd1;
  localparam logic [2:0] S_MUL_B = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL_C = 3'd4;
  localparam logic [2:0] S_MUL_D = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;

  logic [hcse_pkg::K_W-1:0]    filter_k1;
  logic [hcse_pkg::K_W-1:0]    filter_k2;
  logic [hcse_pkg::SPD_W-1:0]  speed_numerator;
  logic [hcse_pkg::CNT_W-1:0]  stall_limit;

  logic [hcse_pkg::HALL_W-1:0] previous_hall;
  logic [hcse_pkg::CNT_W-1:0]  period_count;
  logic [hcse_pkg::CNT_W-1:0]  period_filtered;
  logic [hcse_pkg::SPD_W-1:0]  speed_estimate;
  logic [hcse_pkg::SPD_W-1:0]  speed_smoothed;

  logic [hcse_pkg::PAT_W-1:0]  pat_hold;
  logic [hcse_pkg::FRAC_W-1:0] part;
  logic                        mul_go;
  logic                        div_go;

  hcse_pkg::mul_req_t            mul_req;
  hcse_pkg::div_req_t            div_req;
  logic [hcse_pkg::PROD_W-1:0]   mul_product;
  logic                          mul_done;
  logic [hcse_pkg::SPD_W-1:0]    div_quotient;
  logic                          div_done;

  logic                          slot_free;
  logic                          accept;
  logic                          hall_change;
  logic [hcse_pkg::PAT_W-1:0]    pat_sel;
  logic [hcse_pkg::CNT_W-1:0]    count_inc;
  logic [hcse_pkg::FRAC_W:0]     blend_sum;
  logic [hcse_pkg::CNT_W-1:0]    period_sat;
  logic [hcse_pkg::SPD_W-1:0]    speed_sat;
  logic [hcse_pkg::SPD_W-1:0]    quot_sat;

  hcse_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .product (mul_product),
    .done    (mul_done)
  );

  hcse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .quotient (div_quotient),
    .done     (div_done)
  );

  assign slot_free   = !result_valid || !result_stall;
  assign hall_stall  = !((state == S_IDLE) && slot_free);
  assign accept      = hall_valid && !hall_stall;
  assign hall_change = (hall_code != previous_hall);

  always_comb begin
    priority if (dir_mode == hcse_pkg::MODE_FWD) begin
      pat_sel = hcse_pkg::fwd_pattern(hall_code);
    end else if (dir_mode == hcse_pkg::MODE_REV) begin
      pat_sel = hcse_pkg::rev_pattern(hall_code);
    end else begin
      pat_sel = hcse_pkg::PAT_NONE;
    end
  end

  always_comb begin
    mul_req.start = mul_go;
    unique case (state)
      S_MUL_A: begin
        mul_req.k = filter_k2;
        mul_req.x = hcse_pkg::SPD_W'(period_filtered);
      end
      S_MUL_B: begin
        mul_req.k = filter_k1;
        mul_req.x = hcse_pkg::SPD_W'(period_count);
      end
      S_MUL_C: begin
        mul_req.k = filter_k2;
        mul_req.x = speed_smoothed;
      end
      default: begin
        mul_req.k = filter_k1;
        mul_req.x = speed_estimate;
      end
    endcase
    div_req.start    = div_go;
    div_req.dividend = speed_numerator;
    div_req.divisor  = period_filtered;
  end

  always_comb begin
    count_inc  = (period_count < hcse_pkg::PERIOD_MAX) ?
                 period_count + hcse_pkg::CNT_W'(1) : period_count;
    blend_sum  = {1'b0, part} + {1'b0, mul_product[hcse_pkg::PROD_W-1:hcse_pkg::Q_SHIFT]};
    period_sat = (blend_sum > (hcse_pkg::FRAC_W + 1)'(hcse_pkg::PERIOD_MAX)) ?
                 hcse_pkg::PERIOD_MAX : blend_sum[hcse_pkg::CNT_W-1:0];
    speed_sat  = (blend_sum > (hcse_pkg::FRAC_W + 1)'(hcse_pkg::SPEED_MAX)) ?
                 hcse_pkg::SPEED_MAX : blend_sum[hcse_pkg::SPD_W-1:0];
    quot_sat   = (div_quotient > hcse_pkg::SPEED_MAX) ? hcse_pkg::SPEED_MAX : div_quotient;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_k1       <= hcse_pkg::RST_FILTER_K1;
      filter_k2       <= hcse_pkg::RST_FILTER_K2;
      speed_numerator <= hcse_pkg::RST_SPEED_NUM;
      stall_limit     <= hcse_pkg::RST_STALL_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hcse_pkg::REG_FILTER_K1:   filter_k1       <= cfg_data[hcse_pkg::K_W-1:0];
        hcse_pkg::REG_FILTER_K2:   filter_k2       <= cfg_data[hcse_pkg::K_W-1:0];
        hcse_pkg::REG_SPEED_NUM:   speed_numerator <= cfg_data[hcse_pkg::SPD_W-1:0];
        hcse_pkg::REG_STALL_LIMIT: stall_limit     <= cfg_data[hcse_pkg::CNT_W-1:0];
      endcase
    end
  end

  // sequencer, estimator state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      mul_go          <= 1'b0;
      div_go          <= 1'b0;
      result_valid    <= 1'b0;
      previous_hall   <= '0;
      period_count    <= '0;
      period_filtered <= '0;
      speed_estimate  <= '0;
      speed_smoothed  <= '0;
    end else begin
      mul_go <= 1'b0;
      div_go <= 1'b0;
      if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            previous_hall <= hall_code;
            if (drive_enable && hall_change) begin
              pat_hold <= pat_sel;
              mul_go   <= 1'b1;
              state    <= S_MUL_A;
            end else begin
              result_valid   <= 1'b1;
              drive_pattern  <= hcse_pkg::PAT_NONE;
              speed_raw      <= speed_estimate;
              speed_filtered <= speed_smoothed;
              stall_event    <= 1'b0;
              if (drive_enable) begin
                if (count_inc >= stall_limit) begin
                  period_count   <= '0;
                  speed_smoothed <= '0;
                  speed_filtered <= '0;
                  stall_event    <= 1'b1;
                end else begin
                  period_count <= count_inc;
                end
              end
            end
          end
        end
        S_MUL_A: begin
          if (mul_done) begin
            part   <= mul_product[hcse_pkg::PROD_W-1:hcse_pkg::Q_SHIFT];
            mul_go <= 1'b1;
            state  <= S_MUL_B;
          end
        end
        S_MUL_B: begin
          if (mul_done) begin
            period_filtered <= period_sat;
            period_count    <= '0;
            if (period_sat == '0) begin
              speed_estimate <= '0;
              mul_go         <= 1'b1;
              state          <= S_MUL_C;
            end else begin
              div_go <= 1'b1;
              state  <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            speed_estimate <= quot_sat;
            mul_go         <= 1'b1;
            state          <= S_MUL_C;
          end
        end
        S_MUL_C: begin
          if (mul_done) begin
            part   <= mul_product[hcse_pkg::PROD_W-1:hcse_pkg::Q_SHIFT];
            mul_go <= 1'b1;
            state  <= S_MUL_D;
          end
        end
        S_MUL_D: begin
          if (mul_done) begin
            speed_smoothed <= speed_sat;
            state          <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            result_valid   <= 1'b1;
            drive_pattern  <= pat_hold;
            speed_raw      <= speed_estimate;
            speed_filtered <= speed_smoothed;
            stall_event    <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // no input word is taken while a hall change is in progress
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> hall_stall)
    else $error("input taken while computing");

  // multiplier finishes only in a multiply step
  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_MUL_A || state == S_MUL_B ||
                  state == S_MUL_C || state == S_MUL_D))
    else $error("multiplier done outside multiply step");

  // divider finishes only in the divide step
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider done outside divide step");

  // a stall word carries a zero filtered speed and no pattern
  a_stall_word: assert property (@(posedge clk) disable iff (rst)
    (result_valid && stall_event) |->
      (speed_filtered == '0 && drive_pattern == hcse_pkg::PAT_NONE))
    else $error("stall word with nonzero speed or pattern");

  // speeds stay within saturation bound
  a_speed_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (speed_raw <= hcse_pkg::SPEED_MAX &&
                      speed_filtered <= hcse_pkg::SPEED_MAX))
    else $error("speed above saturation bound");

endmodule
